@@ src/tlbpt_pkg.sv @@
// Shared types and constants of the TLB / page table translator.
// Item payloads, sequencer states and the controller to datapath command and status.
package tlbpt_pkg;

  localparam int unsigned VA_W  = 16;
  localparam int unsigned PA_W  = 16;
  localparam int unsigned CNT_W = 32;

  typedef struct packed {
    logic [VA_W-1:0] virtual_address;
  } va_item_t;

  typedef struct packed {
    logic [PA_W-1:0]  physical_address;
    logic             tlb_hit;
    logic             page_fault;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] fault_total;
  } pa_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PAGE,
    ST_LOOK,
    ST_RESOLVE
  } ctrl_state_e;

  typedef struct packed {
    logic clear_en;
    logic in_ready;
    logic page_en;
    logic look_en;
    logic resolve_en;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } ctrl_stat_t;

endpackage

@@ src/tlbpt_stream_if.sv @@
// Valid/ready stream channel carrying one item payload.
// The payload type is chosen where the channel is instantiated.
interface tlbpt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ src/tlbpt_ctrl.sv @@
// Sequencer of the translator: clearing pass, capture, page index, lookup, resolve.
// Depends on tlbpt_pkg for the state, command and status types.
module tlbpt_ctrl import tlbpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  ctrl_stat_t stat_i,
  output ctrl_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (in_valid_i) state_d = ST_PAGE;
      end
      ST_PAGE: begin
        cmd_o.page_en = 1'b1;
        state_d       = ST_LOOK;
      end
      ST_LOOK: begin
        cmd_o.look_en = 1'b1;
        state_d       = ST_RESOLVE;
      end
      ST_RESOLVE: begin
        // hold until the output register can take the result
        if (stat_i.out_free) begin
          cmd_o.resolve_en = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ src/tlbpt_datapath.sv @@
// Datapath of the translator: page index, TLB entries, page table memory,
// frame allocator, saturating totals and output register. Depends on tlbpt_pkg.
module tlbpt_datapath import tlbpt_pkg::*; #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ctrl_cmd_t  cmd_i,
  output ctrl_stat_t stat_o,
  input  logic       in_valid_i,
  input  va_item_t   in_data_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output pa_item_t   out_data_o
);

  localparam int unsigned TLB_IW   = $clog2(TLB_ENTRIES);
  localparam int unsigned PAGE_W   = $clog2(PAGE_COUNT);
  localparam int unsigned NFF_W    = $clog2(PAGE_COUNT + 1);
  localparam int unsigned RAW_W    = (OFFSET_BITS < VA_W) ? (VA_W - OFFSET_BITS) : 1;
  localparam int unsigned RECIP_SH = 24;
  localparam logic [31:0] RECIP    = 32'((64'd1 << RECIP_SH) / PAGE_COUNT);
  localparam logic [31:0] PC32     = 32'(PAGE_COUNT);
  localparam logic [VA_W-1:0] OFF_MASK = VA_W'((32'd1 << OFFSET_BITS) - 32'd1);
  localparam logic [TLB_IW-1:0] FIFO_LAST  = TLB_IW'(TLB_ENTRIES - 1);
  localparam logic [PAGE_W-1:0] CLEAR_LAST = PAGE_W'(PAGE_COUNT - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX    = '1;

  // capture and quotient estimate
  logic [VA_W-1:0]  va_q;
  logic [RAW_W-1:0] quot_q;
  logic [RAW_W-1:0] raw_in, raw_cur;
  logic [31:0]      prod;
  logic [31:0]      rem;
  logic [PAGE_W-1:0] page_q;

  assign raw_in  = RAW_W'(32'(in_data_i.virtual_address) >> OFFSET_BITS);
  assign raw_cur = RAW_W'(32'(va_q) >> OFFSET_BITS);
  assign prod    = 32'(raw_in) * RECIP;
  assign rem     = 32'(raw_cur) - 32'(quot_q) * PC32;

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_ready && in_valid_i) begin
      va_q   <= in_data_i.virtual_address;
      quot_q <= RAW_W'(prod >> RECIP_SH);
    end
    if (cmd_i.page_en) begin
      // estimate is at most one short: one correction
      page_q <= (rem >= PC32) ? PAGE_W'(rem - PC32) : PAGE_W'(rem);
    end
  end

  // TLB entries
  logic                 tlb_valid_q [TLB_ENTRIES];
  logic [PAGE_W-1:0]    tlb_page_q  [TLB_ENTRIES];
  logic [PAGE_W-1:0]    tlb_frame_q [TLB_ENTRIES];
  logic [TLB_IW-1:0]    fifo_q;
  logic                 look_hit;
  logic [PAGE_W-1:0]    look_frame;
  logic                 hit_q;
  logic [PAGE_W-1:0]    hit_frame_q;

  always_comb begin
    look_hit   = 1'b0;
    look_frame = '0;
    // lowest matching entry wins
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && (tlb_page_q[i] == page_q)) begin
        look_hit   = 1'b1;
        look_frame = tlb_frame_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look_en) begin
      hit_q       <= look_hit;
      hit_frame_q <= look_frame;
    end
  end

  // page table: valid bit and frame per page, cleared by a sweep after reset
  logic [PAGE_W:0]   map_mem [PAGE_COUNT];
  logic [PAGE_W:0]   map_rd_q;
  logic [PAGE_W-1:0] clr_q;

  // resolve
  logic [NFF_W-1:0]  nff_q;
  logic [CNT_W-1:0]  hit_cnt_q, fault_cnt_q;
  logic [CNT_W-1:0]  hit_cnt_d, fault_cnt_d;
  logic              fault;
  logic [PAGE_W-1:0] frame;

  assign fault = !hit_q && !map_rd_q[PAGE_W];
  assign frame = hit_q            ? hit_frame_q :
                 map_rd_q[PAGE_W] ? map_rd_q[PAGE_W-1:0] : nff_q[PAGE_W-1:0];

  assign hit_cnt_d   = (hit_q && (hit_cnt_q != CNT_MAX)) ? hit_cnt_q + 1'b1 : hit_cnt_q;
  assign fault_cnt_d = (fault && (fault_cnt_q != CNT_MAX)) ? fault_cnt_q + 1'b1
                                                           : fault_cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_en) begin
      map_mem[clr_q] <= '0;
    end else if (cmd_i.resolve_en && fault) begin
      map_mem[page_q] <= {1'b1, nff_q[PAGE_W-1:0]};
    end
    if (cmd_i.look_en) begin
      map_rd_q <= map_mem[page_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve_en && !hit_q) begin
      tlb_page_q[fifo_q]  <= page_q;
      tlb_frame_q[fifo_q] <= frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TLB_ENTRIES; i++) tlb_valid_q[i] <= 1'b0;
      fifo_q      <= '0;
      clr_q       <= '0;
      nff_q       <= '0;
      hit_cnt_q   <= '0;
      fault_cnt_q <= '0;
    end else begin
      if (cmd_i.clear_en) clr_q <= clr_q + 1'b1;
      if (cmd_i.resolve_en) begin
        hit_cnt_q   <= hit_cnt_d;
        fault_cnt_q <= fault_cnt_d;
        if (!hit_q) begin
          tlb_valid_q[fifo_q] <= 1'b1;
          fifo_q <= (fifo_q == FIFO_LAST) ? '0 : fifo_q + 1'b1;
        end
        if (fault && (nff_q != NFF_W'(PAGE_COUNT))) nff_q <= nff_q + 1'b1;
      end
    end
  end

  // output register
  logic     out_valid_q;
  pa_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resolve_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resolve_en) begin
      out_data_q.physical_address <= PA_W'((32'(frame) << OFFSET_BITS) |
                                           32'(va_q & OFF_MASK));
      out_data_q.tlb_hit     <= hit_q;
      out_data_q.page_fault  <= fault;
      out_data_q.hit_total   <= hit_cnt_d;
      out_data_q.fault_total <= fault_cnt_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.clear_last = (clr_q == CLEAR_LAST);

endmodule

@@ src/tlb_page_table_translator.sv @@
// Top level of the TLB / page table translator with FIFO replacement.
// Depends on tlbpt_pkg, tlbpt_stream_if, tlbpt_ctrl and tlbpt_datapath.
//
// Use:
//   in_if  (sink)   carries one virtual address per item: page number above the
//                   low OFFSET_BITS offset bits.
//   out_if (source) carries one result per item: physical address, TLB hit and
//                   page fault flags, and saturating hit and fault totals.
//   Both channels move an item on a rising edge with valid and ready high.
// Sequence:
//   After reset the page table is swept clear, one entry a cycle, through
//   all PAGE_COUNT entries; in_if.ready stays low during the sweep.
//   The sequencer walks capture, page index, TLB compare with page table
//   read, and resolve into the output register; the next item is taken only
//   after the resolve step, so the block works on one item at a time.
//   The page table memory has one port, read in the lookup step and written
//   in the resolve step.
// Stall:
//   A result waits in the output register while out_if.ready is low. The next
//   item is still accepted and worked on; it holds in the resolve step until
//   the output register frees up.
module tlb_page_table_translator import tlbpt_pkg::*; #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned OFFSET_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tlbpt_stream_if.sink          in_if,
  tlbpt_stream_if.source        out_if
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;
  pa_item_t   out_data;
  va_item_t   in_data;

  assign in_data     = in_if.data;
  assign in_if.ready = cmd.in_ready;
  assign out_if.data = out_data;

  tlbpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .PAGE_COUNT  (PAGE_COUNT),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_valid_i  (in_if.valid),
    .in_data_i   (in_data),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .out_data_o  (out_data)
  );

  // one item in flight: no new item during page index and lookup
  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready ##1 !in_if.ready)
    else $error("item accepted while another is in flight");

  // a result is loaded only when the output register is free
  a_resolve_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.resolve_en |-> (!out_if.valid || out_if.ready))
    else $error("result overwrote a waiting item");

  // a fault only happens on a TLB miss
  a_hit_fault_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !(out_if.data.tlb_hit && out_if.data.page_fault))
    else $error("TLB hit flagged as page fault");

  // no item is taken during the clearing sweep
  a_no_accept_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear_en |-> !in_if.ready)
    else $error("ready raised during page table clear");

endmodule

@@ sim/tlb_page_table_translator_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for tlb_page_table_translator: directed and random address streams.
// Depends on tlbpt_pkg, tlbpt_stream_if and the translator RTL.

// Track the translator's state and queue the result that each accepted address must give.
class translation_board;
  localparam int unsigned TLB_N  = 16;
  localparam int unsigned PAGE_N = 256;
  localparam int unsigned OFF_W  = 8;

  bit          tlb_valid [TLB_N];
  int unsigned tlb_page  [TLB_N];
  int unsigned tlb_frame [TLB_N];
  bit          map_valid [PAGE_N];
  int unsigned map_frame [PAGE_N];
  int unsigned next_frame;
  int unsigned fifo_slot;
  bit [31:0]   hit_cnt;
  bit [31:0]   fault_cnt;

  tlbpt_pkg::pa_item_t expected_pa[$];
  int unsigned         n_in;
  int unsigned         errors;

  function new();
    foreach (tlb_valid[i]) tlb_valid[i] = 1'b0;
    foreach (map_valid[i]) map_valid[i] = 1'b0;
    next_frame = 0;
    fifo_slot  = 0;
    hit_cnt    = '0;
    fault_cnt  = '0;
    n_in       = 0;
    errors     = 0;
  endfunction

  // Translate one accepted address and queue its result.
  function void note_va(tlbpt_pkg::va_item_t it);
    int unsigned         va;
    int unsigned         off;
    int unsigned         page;
    int unsigned         frame;
    bit                  hit;
    bit                  fault;
    tlbpt_pkg::pa_item_t res;
    va    = 32'(it.virtual_address);
    off   = va & ((1 << OFF_W) - 1);
    page  = (va >> OFF_W) % PAGE_N;
    frame = 0;
    hit   = 1'b0;
    fault = 1'b0;
    // Lowest matching slot wins.
    for (int i = 0; i < TLB_N; i++) begin
      if (!hit && tlb_valid[i] && tlb_page[i] == page) begin
        hit   = 1'b1;
        frame = tlb_frame[i];
      end
    end
    if (hit) begin
      if (hit_cnt != 32'hFFFF_FFFF) hit_cnt++;
    end else begin
      if (map_valid[page]) begin
        frame = map_frame[page];
      end else begin
        frame           = next_frame;
        map_frame[page] = frame;
        map_valid[page] = 1'b1;
        if (next_frame < PAGE_N) next_frame++;
        fault = 1'b1;
        if (fault_cnt != 32'hFFFF_FFFF) fault_cnt++;
      end
      tlb_page[fifo_slot]  = page;
      tlb_frame[fifo_slot] = frame;
      tlb_valid[fifo_slot] = 1'b1;
      fifo_slot            = (fifo_slot + 1) % TLB_N;
    end
    res.physical_address = 16'((frame << OFF_W) | off);
    res.tlb_hit          = hit;
    res.page_fault       = fault;
    res.hit_total        = hit_cnt;
    res.fault_total      = fault_cnt;
    expected_pa.push_back(res);
    n_in++;
  endfunction

  // Compare one accepted result with the oldest queued one.
  function void check_pa(tlbpt_pkg::pa_item_t got);
    tlbpt_pkg::pa_item_t want;
    if (expected_pa.size() == 0) begin
      $error("unexpected result item: physical_address %h", got.physical_address);
      errors++;
      return;
    end
    want = expected_pa.pop_front();
    if (got.physical_address !== want.physical_address) begin
      $error("physical_address: expected %h, got %h", want.physical_address,
             got.physical_address);
      errors++;
    end
    if (got.tlb_hit !== want.tlb_hit) begin
      $error("tlb_hit: expected %b, got %b", want.tlb_hit, got.tlb_hit);
      errors++;
    end
    if (got.page_fault !== want.page_fault) begin
      $error("page_fault: expected %b, got %b", want.page_fault, got.page_fault);
      errors++;
    end
    if (got.hit_total !== want.hit_total) begin
      $error("hit_total: expected %0d, got %0d", want.hit_total, got.hit_total);
      errors++;
    end
    if (got.fault_total !== want.fault_total) begin
      $error("fault_total: expected %0d, got %0d", want.fault_total, got.fault_total);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return expected_pa.size();
  endfunction
endclass

module tlb_page_table_translator_tb;
  import tlbpt_pkg::*;

  localparam int unsigned TLB_N         = 16;
  localparam int unsigned PAGE_N        = 256;
  localparam int unsigned OFF_W         = 8;
  localparam int unsigned PHASE_ITEMS   = 560;
  localparam int unsigned LONG_HOLD_CYC = 400;
  localparam int unsigned DRAIN_CYC     = 40;

  logic clk_i;
  logic rst_ni;

  tlbpt_stream_if #(.payload_t(va_item_t)) va_if ();
  tlbpt_stream_if #(.payload_t(pa_item_t)) pa_if ();

  tlb_page_table_translator #(
    .TLB_ENTRIES (TLB_N),
    .PAGE_COUNT  (PAGE_N),
    .OFFSET_BITS (OFF_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (va_if),
    .out_if (pa_if)
  );

  translation_board sb = new();

  // Idle chances in percent, changed between phases by the main sequence.
  int unsigned src_idle_pct = 25;
  int unsigned snk_idle_pct = 74;
  // Input count at which the receiver starts its long hold-off; zero disarms it.
  int unsigned hold_at      = 0;
  bit          hold_done    = 1'b0;

  // Stimulus history: recently sent pages, and pages ever sent.
  int unsigned page_hist[$];
  bit          touched [256];

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Sample both channels at the rising edge; note inputs before checking outputs.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (va_if.valid && va_if.ready) sb.note_va(va_if.data);
      if (pa_if.valid && pa_if.ready) sb.check_pa(pa_if.data);
    end
  end

  // Receiver: drop ready at random, and once hold it off long enough that the
  // block backs up and stalls its input while the sender keeps offering.
  initial begin
    pa_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && hold_at != 0 && sb.n_in >= hold_at) begin
        hold_done = 1'b1;
        pa_if.ready <= 1'b0;
        repeat (LONG_HOLD_CYC - 1) @(negedge clk_i);
      end else begin
        pa_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Offer one address, idling first at random; return at the falling edge after
  // the item is taken, with valid still high so the next call may keep it up.
  task automatic push_va(input logic [15:0] va);
    while ($urandom_range(99) < src_idle_pct) begin
      va_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    va_if.valid                <= 1'b1;
    va_if.data.virtual_address <= va;
    do @(posedge clk_i); while (!va_if.ready);
    @(negedge clk_i);
    touched[va[15:8]] = 1'b1;
    page_hist.push_back(32'(va[15:8]));
    if (page_hist.size() > 32) void'(page_hist.pop_front());
  endtask

  // Mostly reuse recent pages so the TLB sees hits, evictions and refills;
  // mix in never-seen pages (faults) and fully random addresses.
  function automatic logic [15:0] pick_va();
    int unsigned roll;
    int unsigned span;
    int unsigned start;
    logic [7:0]  page;
    logic [7:0]  off;
    bit          found;
    roll = $urandom_range(99);
    off  = 8'($urandom_range(255));
    page = 8'($urandom_range(255));
    if (page_hist.size() != 0 && roll < 55) begin
      // Last dozen pages: likely still cached.
      span = (page_hist.size() < 12) ? page_hist.size() : 12;
      page = 8'(page_hist[page_hist.size() - 1 - $urandom_range(span - 1)]);
    end else if (page_hist.size() != 0 && roll < 82) begin
      // Anywhere in the history: often evicted but already mapped.
      page = 8'(page_hist[$urandom_range(page_hist.size() - 1)]);
    end else if (roll < 90) begin
      start = $urandom_range(255);
      found = 1'b0;
      for (int k = 0; k < 256; k++) begin
        if (!found && !touched[(start + k) % 256]) begin
          found = 1'b1;
          page  = 8'((start + k) % 256);
        end
      end
    end
    return {page, off};
  endfunction

  initial begin
    va_if.valid = 1'b0;
    va_if.data  = '0;
    rst_ni      = 1'b0;
    foreach (touched[i]) touched[i] = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes of page and offset, a hit right after the fault,
    // then fill the TLB, wrap the FIFO pointer, and touch evicted pages
    // again (a miss on a mapped page, so no fault).
    push_va(16'h0000);
    push_va(16'h0000);
    push_va(16'h00FF);
    push_va(16'hFFFF);
    push_va(16'hFF00);
    push_va(16'h5AA5);
    push_va(16'hA55A);
    for (int p = 1; p <= 12; p++) push_va({8'(p), 8'(p * 17)});
    push_va(16'h0D12);
    push_va(16'h0034);
    push_va(16'hFF80);

    // Random: sender idles lightly while the receiver idles heavily, then the
    // reverse, then neither idles with one long receiver hold-off.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 25;
          snk_idle_pct = 74;
        end
        1: begin
          src_idle_pct = 74;
          snk_idle_pct = 25;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          hold_at      = sb.n_in + 40;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) push_va(pick_va());
    end
    va_if.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run, clearing sweep included.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
